// ===== rtl/core/ffpa_pkg.sv =====
// Package for the first-fit page extent allocator.
// Request codes, status codes, controller states and default sizes.
// No dependencies.
package ffpa_pkg;

  localparam int unsigned MaxExtentsDefault  = 64;
  localparam int unsigned PageAddrBitsDefault = 20;

  typedef enum logic {
    ACT_FREE  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_OVERLAP = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_FDEC = 7'b0000100,
    S_SUP  = 7'b0001000,
    S_INS  = 7'b0010000,
    S_SDN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

endpackage

// ===== rtl/core/ffpa_if.sv =====
// Request and response channel interfaces of the page extent allocator.
// Depends on nothing; widths follow PAGE_ADDR_BITS.
interface ffpa_req_if #(
  parameter int unsigned PAGE_ADDR_BITS = 20
);
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [PAGE_ADDR_BITS-1:0] page_start;
  logic [PAGE_ADDR_BITS:0]   page_count;
  logic [PAGE_ADDR_BITS:0]   min_pages;
  logic [PAGE_ADDR_BITS:0]   max_pages;

  modport source (output valid, action, page_start, page_count, min_pages, max_pages,
                  input ready);
  modport sink   (input valid, action, page_start, page_count, min_pages, max_pages,
                  output ready);
endinterface

interface ffpa_rsp_if #(
  parameter int unsigned PAGE_ADDR_BITS = 20
);
  logic                      valid;
  logic                      ready;
  logic [PAGE_ADDR_BITS-1:0] grant_start;
  logic [PAGE_ADDR_BITS:0]   grant_pages;
  logic [1:0]                status;
  logic [PAGE_ADDR_BITS:0]   free_total;

  modport source (output valid, grant_start, grant_pages, status, free_total,
                  input ready);
  modport sink   (input valid, grant_start, grant_pages, status, free_total,
                  output ready);
endinterface

// ===== rtl/core/ffpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/first_fit_page_extent_allocator.sv =====
// First-fit page extent allocator, top level.
// Depends on ffpa_pkg, ffpa_if (request/response channels) and ffpa_ram.
//
// Usage: a request on req_i either frees an extent (page_start, page_count) or
// allocates (min_pages, max_pages). Each request gives exactly one response on
// rsp_o with grant_start, grant_pages, status and the free page total after it.
// The extent table sits in one RAM with a registered read; it is kept sorted by
// start page. A request walks the table one entry per cycle until it finds its
// place (free) or the first fitting extent (allocate), then may shift entries
// one per cycle to open or close a slot. A free into an empty table skips the
// walk; a free of zero pages or an allocate on an empty table skips the walk and
// the shift. One request is in work at a time; req_i.ready is high in idle. The
// response sits in an output register, so a finished request frees the engine
// while the response waits; a stalled receiver holds the next response in the
// engine until the register drains.
// Reset empties the table (count and free total cleared); no clearing pass.
module first_fit_page_extent_allocator
  import ffpa_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS    = MaxExtentsDefault,
  parameter int unsigned PAGE_ADDR_BITS = PageAddrBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffpa_req_if.sink   req_i,
  ffpa_rsp_if.source rsp_o
);
  localparam int unsigned PA   = PAGE_ADDR_BITS;
  localparam int unsigned CW   = PA + 1;
  localparam int unsigned IW   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_EXTENTS + 1);

  typedef struct packed {
    logic [PA-1:0] start;
    logic [CW-1:0] size;
  } ext_t;

  localparam logic [PA+1:0] PageLimit = {2'b01, {PA{1'b0}}};

  state_e state_q, state_d;
  logic [CNTW-1:0] idx_q, idx_d, k_q, k_d, cnt_q, cnt_d;
  logic [CW-1:0]   total_q, total_d;
  logic            act_q, act_d;
  logic [PA-1:0]   s_q, s_d;
  logic [CW-1:0]   n_q, n_d, mn_q, mn_d, mx_q, mx_d;
  ext_t            pred_q, pred_d, succ_q, succ_d;
  logic            has_succ_q, has_succ_d;
  logic [PA-1:0]   gs_q, gs_d;
  logic [CW-1:0]   gp_q, gp_d;
  status_e         st_q, st_d;

  logic            out_valid_q, out_valid_d;
  logic [PA-1:0]   out_gs_q, out_gs_d;
  logic [CW-1:0]   out_gp_q, out_gp_d;
  status_e         out_st_q, out_st_d;
  logic [CW-1:0]   out_tot_q, out_tot_d;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  ext_t            wdata, rdata;

  ffpa_ram #(
    .WIDTH ($bits(ext_t)),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.grant_start = out_gs_q;
  assign rsp_o.grant_pages = out_gp_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.free_total  = out_tot_q;

  logic [PA+1:0]   req_end, end_q, pred_end;
  logic [CNTW-1:0] nxt;
  logic            has_pred, ovl, jp, js;

  assign req_end  = {2'b00, req_i.page_start} + {1'b0, req_i.page_count};
  assign end_q    = {2'b00, s_q} + {1'b0, n_q};
  assign pred_end = {2'b00, pred_q.start} + {1'b0, pred_q.size};
  assign has_pred = (idx_q != '0);
  assign ovl      = (has_pred && pred_end > {2'b00, s_q}) ||
                    (has_succ_q && end_q > {2'b00, succ_q.start});
  assign jp       = has_pred && (pred_end == {2'b00, s_q});
  assign js       = has_succ_q && ({2'b00, succ_q.start} == end_q);
  assign nxt      = idx_q + CNTW'(1);

  always_comb begin
    logic          rm_go;
    logic [CW-1:0] msize;
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    act_d       = act_q;
    s_d         = s_q;
    n_d         = n_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    pred_d      = pred_q;
    succ_d      = succ_q;
    has_succ_d  = has_succ_q;
    gs_d        = gs_q;
    gp_d        = gp_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_gs_d    = out_gs_q;
    out_gp_d    = out_gp_q;
    out_st_d    = out_st_q;
    out_tot_d   = out_tot_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    rm_go       = 1'b0;
    msize       = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d = req_i.action;
          s_d   = req_i.page_start;
          n_d   = req_i.page_count;
          mn_d  = (req_i.min_pages == '0) ? CW'(1) : req_i.min_pages;
          mx_d  = req_i.max_pages;
          gs_d  = '0;
          gp_d  = '0;
          st_d  = ST_OK;
          idx_d = '0;
          has_succ_d = 1'b0;
          if (req_i.action == ACT_FREE) begin
            if (req_i.page_count == '0) begin
              state_d = S_DONE;
            end else if (req_end > PageLimit) begin
              st_d    = ST_OVERLAP;
              state_d = S_DONE;
            end else if (cnt_q == '0) begin
              state_d = S_FDEC;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            if (cnt_q == '0) begin
              st_d    = ST_NOFIT;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end

      // rdata holds entry idx_q
      S_SCAN: begin
        if (act_q == ACT_FREE) begin
          if (rdata.start < s_q) begin
            pred_d = rdata;
            idx_d  = nxt;
            if (nxt == cnt_q) begin
              has_succ_d = 1'b0;
              state_d    = S_FDEC;
            end else begin
              raddr = nxt[IW-1:0];
            end
          end else begin
            succ_d     = rdata;
            has_succ_d = 1'b1;
            state_d    = S_FDEC;
          end
        end else begin
          if (rdata.size >= mn_q) begin
            gs_d = rdata.start;
            if (mx_q < rdata.size && rdata.size > mn_q) begin
              we          = 1'b1;
              waddr       = idx_q[IW-1:0];
              wdata.start = rdata.start + mn_q[PA-1:0];
              wdata.size  = rdata.size - mn_q;
              gp_d        = mn_q;
              total_d     = total_q - mn_q;
              state_d     = S_DONE;
            end else begin
              gp_d    = rdata.size;
              total_d = total_q - rdata.size;
              rm_go   = 1'b1;
            end
          end else begin
            idx_d = nxt;
            if (nxt == cnt_q) begin
              st_d    = ST_NOFIT;
              state_d = S_DONE;
            end else begin
              raddr = nxt[IW-1:0];
            end
          end
        end
      end

      S_FDEC: begin
        if (ovl) begin
          st_d    = ST_OVERLAP;
          state_d = S_DONE;
        end else if (jp) begin
          msize = pred_q.size + n_q;
          if (js) begin
            msize = msize + succ_q.size;
          end
          we          = 1'b1;
          waddr       = IW'(idx_q - CNTW'(1));
          wdata.start = pred_q.start;
          wdata.size  = msize;
          total_d     = total_q + n_q;
          if (js) begin
            rm_go = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end else if (js) begin
          we          = 1'b1;
          waddr       = idx_q[IW-1:0];
          wdata.start = s_q;
          wdata.size  = succ_q.size + n_q;
          total_d     = total_q + n_q;
          state_d     = S_DONE;
        end else if (cnt_q == CNTW'(MAX_EXTENTS)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          total_d = total_q + n_q;
          if (cnt_q > idx_q) begin
            raddr   = IW'(cnt_q - CNTW'(1));
            k_d     = cnt_q;
            state_d = S_SUP;
          end else begin
            state_d = S_INS;
          end
        end
      end

      // open a slot: entry k-1 moves to k, walking down
      S_SUP: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rdata;
        if (k_q - CNTW'(1) > idx_q) begin
          raddr = IW'(k_q - CNTW'(2));
          k_d   = k_q - CNTW'(1);
        end else begin
          state_d = S_INS;
        end
      end

      S_INS: begin
        we          = 1'b1;
        waddr       = idx_q[IW-1:0];
        wdata.start = s_q;
        wdata.size  = n_q;
        cnt_d       = cnt_q + CNTW'(1);
        state_d     = S_DONE;
      end

      // close a slot: entry k+1 moves to k, walking up
      S_SDN: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rdata;
        if (k_q + CNTW'(2) < cnt_q) begin
          raddr = IW'(k_q + CNTW'(2));
          k_d   = k_q + CNTW'(1);
        end else begin
          cnt_d   = cnt_q - CNTW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_gs_d    = gs_q;
          out_gp_d    = gp_q;
          out_st_d    = st_q;
          out_tot_d   = total_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // remove entry idx_q
    if (rm_go) begin
      k_d = idx_q;
      if (nxt < cnt_q) begin
        raddr   = nxt[IW-1:0];
        state_d = S_SDN;
      end else begin
        cnt_d   = cnt_q - CNTW'(1);
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    k_q        <= k_d;
    act_q      <= act_d;
    s_q        <= s_d;
    n_q        <= n_d;
    mn_q       <= mn_d;
    mx_q       <= mx_d;
    pred_q     <= pred_d;
    succ_q     <= succ_d;
    has_succ_q <= has_succ_d;
    gs_q       <= gs_d;
    gp_q       <= gp_d;
    st_q       <= st_d;
    out_gs_q   <= out_gs_d;
    out_gp_q   <= out_gp_d;
    out_st_q   <= out_st_d;
    out_tot_q  <= out_tot_d;
  end

endmodule
